// ===== hw/rtl/biquad_coefficient_designer_macros.svh =====
// ----------------------------------------------------------------------------
// biquad coefficient designer assertion macros
// concurrent checks that vanish when the design is synthesized
// ----------------------------------------------------------------------------
`ifndef BIQUAD_COEFFICIENT_DESIGNER_MACROS_SVH
`define BIQUAD_COEFFICIENT_DESIGNER_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BQCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bqcd check failed");
// antecedent implies consequent a fixed number of cycles later
`define BQCD_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("bqcd latency check failed");
`else
`define BQCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BQCD_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons)
`endif

`endif

// ===== hw/rtl/bqcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bqcd_pkg
// shared widths, constants, payload types and the cordic angle table
// ----------------------------------------------------------------------------
`default_nettype none

package bqcd_pkg;

    localparam int COEF_FRAC_BITS_DEF = 29;
    localparam int CORDIC_STEPS_DEF   = 24;

    localparam int SR_W     = 18;
    localparam int FC_W     = 17;
    localparam int QUAL_W   = 16;
    localparam int COEF_W   = 32;
    localparam int PHASE_W  = 32;
    localparam int CORDIC_W = 34;
    localparam int NUM_W    = 36;
    localparam int MAG_W    = 35;

    localparam logic [SR_W-1:0]            SR_RESET    = 18'd48000;
    localparam logic [QUAL_W-1:0]          MIN_QUALITY = 16'd410;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [NUM_W-1:0]    ONE_Q30     = 36'sd1073741824;

    localparam logic CMD_LOWPASS  = 1'b0;
    localparam logic CMD_HIGHPASS = 1'b1;

    typedef struct packed {
        logic              command;
        logic [FC_W-1:0]   cutoff_hz;
        logic [QUAL_W-1:0] quality;
    } cmd_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_b0;
        logic signed [COEF_W-1:0] coef_b1;
        logic signed [COEF_W-1:0] coef_b2;
        logic signed [COEF_W-1:0] coef_a1;
        logic signed [COEF_W-1:0] coef_a2;
    } coef_t;

    // atan(2^-i) in turns, q0.32
    function automatic logic [PHASE_W-1:0] atan_turn(input int idx);
        logic [PHASE_W-1:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            24:      v = 32'd41;
            25:      v = 32'd20;
            26:      v = 32'd10;
            27:      v = 32'd5;
            28:      v = 32'd3;
            29:      v = 32'd1;
            30:      v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/biquad_coefficient_designer.sv =====
// ----------------------------------------------------------------------------
// biquad_coefficient_designer
// cookbook low-pass / high-pass biquad coefficients from cutoff, q and fs
// ----------------------------------------------------------------------------
// A fully pipelined row of cells: busy is never raised, so a command transfer
// can be issued on every clock, and each one yields exactly one coefficient set
// on the result ports, flagged by done for a single cycle. Every transfer runs
// through the chain in order: 49 long-division cells for the phase fc*2^32/fs,
// CORDIC_STEPS rotation cells, one unfold stage, 42 division cells for alpha,
// four numerator stages, 32 division cells that the four coefficient lanes
// share, and one output register. The receiver cannot stall, so done must be
// taken when it shows. The user must write the sample rate register with
// cfg_we / cfg_wdata only while no command is in flight; the block does not
// enforce this. A zero sample rate is treated as 1 Hz.
`default_nettype none

`include "biquad_coefficient_designer_macros.svh"

module biquad_coefficient_designer #(
    parameter int COEF_FRAC_BITS = bqcd_pkg::COEF_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS   = bqcd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  bqcd_pkg::cmd_t              cmd,
    output logic                        done,
    output bqcd_pkg::coef_t             coef,
    input  logic                        cfg_we,
    input  logic [bqcd_pkg::SR_W-1:0]   cfg_wdata
);

    import bqcd_pkg::*;

    // pipeline geometry
    localparam int PH_N      = FC_W + PHASE_W;     // phase dividend bits
    localparam int PH_ACC_W  = SR_W + PH_N;
    localparam int PH_SIDE_W = 1 + QUAL_W;         // highpass, clamped q
    localparam int CD_SIDE_W = 1 + PH_SIDE_W;      // plus quadrant flip
    localparam int SIN_MAG_W = 31;                 // |sin| stays below 2^31
    localparam int QSCALE    = 11;                 // sin * 2048
    localparam int AL_N      = SIN_MAG_W + QSCALE;
    localparam int AL_ACC_W  = QUAL_W + AL_N;
    localparam int AL_SIDE_W = 2 + CORDIC_W;       // sin sign, highpass, cos
    localparam int CF_LANES  = 4;
    localparam int CF_N      = COEF_W;
    localparam int CF_ACC_W  = MAG_W + CF_N;
    localparam int CF_SIDE_W = 3 * CF_LANES;       // ovf, sign, zero per lane
    localparam int SHIFT_W   = COEF_W - COEF_FRAC_BITS;
    localparam int CMP_W     = MAG_W + SHIFT_W;
    localparam int SH_W      = MAG_W + COEF_FRAC_BITS;
    localparam int LATENCY   = PH_N + CORDIC_STEPS + 1 + AL_N + 4 + CF_N + 1;

    // coefficient lanes of the final divider
    localparam int LANE_B0 = 0;
    localparam int LANE_B1 = 1;
    localparam int LANE_A1 = 2;
    localparam int LANE_A2 = 3;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [COEF_W-1:0]        MIN_MAG  = {1'b1, {(COEF_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // sample rate register
    // ------------------------------------------------------------------
    logic [SR_W-1:0] sample_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SR_RESET;
        end
        else if (cfg_we)
        begin
            sample_rate_reg <= cfg_wdata;
        end
    end

    // never stalls: one command transfer per cycle
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // phase division: p = floor(fc * 2^32 / fs) mod 2^32
    // ------------------------------------------------------------------
    logic                          ph_valid [0:PH_N];
    logic [SR_W-1:0]               ph_den   [0:PH_N];
    logic [0:0][PH_ACC_W-1:0]      ph_acc   [0:PH_N];
    logic [PH_SIDE_W-1:0]          ph_side  [0:PH_N];
    logic                          hp_in;
    logic [QUAL_W-1:0]             q_in;

    assign hp_in = (cmd.command == CMD_HIGHPASS);
    // q below the floor is raised to it
    assign q_in  = (cmd.quality < MIN_QUALITY) ? MIN_QUALITY : cmd.quality;

    assign ph_valid[0]  = start && !busy;
    assign ph_den[0]    = (sample_rate_reg == '0) ? SR_W'(1) : sample_rate_reg;
    assign ph_acc[0][0] = {{SR_W{1'b0}}, cmd.cutoff_hz, {PHASE_W{1'b0}}};
    assign ph_side[0]   = {hp_in, q_in};

    for (genvar k = 0; k < PH_N; k++)
    begin : g_phase
        bqcd_div_cell #(
            .REM_W  (SR_W),
            .N_W    (PH_N),
            .LANES  (1),
            .SIDE_W (PH_SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ph_valid[k]),
            .in_den    (ph_den[k]),
            .in_acc    (ph_acc[k]),
            .in_side   (ph_side[k]),
            .out_valid (ph_valid[k+1]),
            .out_den   (ph_den[k+1]),
            .out_acc   (ph_acc[k+1]),
            .out_side  (ph_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // quadrant fold and cordic rotation
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] phase;
    logic               flip;
    logic [PHASE_W-1:0] z_fold;

    assign phase = ph_acc[PH_N][0][PHASE_W-1:0];
    // second and third quadrants: rotate by half a turn, negate cos and sin
    assign flip   = phase[PHASE_W-1] ^ phase[PHASE_W-2];
    assign z_fold = flip ? {~phase[PHASE_W-1], phase[PHASE_W-2:0]} : phase;

    logic                       cd_valid [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cd_x     [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cd_y     [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cd_z     [0:CORDIC_STEPS];
    logic [CD_SIDE_W-1:0]       cd_side  [0:CORDIC_STEPS];

    assign cd_valid[0] = ph_valid[PH_N];
    assign cd_x[0]     = CORDIC_GAIN;
    assign cd_y[0]     = '0;
    assign cd_z[0]     = $signed({{(CORDIC_W-PHASE_W){z_fold[PHASE_W-1]}}, z_fold});
    assign cd_side[0]  = {flip, ph_side[PH_N]};

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        bqcd_cordic_cell #(
            .STEP   (k),
            .SIDE_W (CD_SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cd_valid[k]),
            .in_x      (cd_x[k]),
            .in_y      (cd_y[k]),
            .in_z      (cd_z[k]),
            .in_side   (cd_side[k]),
            .out_valid (cd_valid[k+1]),
            .out_x     (cd_x[k+1]),
            .out_y     (cd_y[k+1]),
            .out_z     (cd_z[k+1]),
            .out_side  (cd_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // unfold: signed cos, sine as sign and magnitude
    // ------------------------------------------------------------------
    logic                       post_valid_reg;
    logic signed [CORDIC_W-1:0] post_c_reg, post_c_next;
    logic [SIN_MAG_W-1:0]       post_smag_reg, post_smag_next;
    logic                       post_sneg_reg, post_sneg_next;
    logic                       post_hp_reg;
    logic [QUAL_W-1:0]          post_q_reg;
    logic                       cd_flip;
    logic signed [CORDIC_W-1:0] y_abs;

    assign cd_flip = cd_side[CORDIC_STEPS][CD_SIDE_W-1];

    always_comb
    begin
        post_c_next    = cd_flip ? -cd_x[CORDIC_STEPS] : cd_x[CORDIC_STEPS];
        y_abs          = cd_y[CORDIC_STEPS][CORDIC_W-1] ? -cd_y[CORDIC_STEPS]
                                                        : cd_y[CORDIC_STEPS];
        post_smag_next = y_abs[SIN_MAG_W-1:0];
        post_sneg_next = (cd_y[CORDIC_STEPS] != '0) &&
                         (cd_y[CORDIC_STEPS][CORDIC_W-1] ^ cd_flip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            post_valid_reg <= 1'b0;
        end
        else
        begin
            post_valid_reg <= cd_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        post_c_reg    <= post_c_next;
        post_smag_reg <= post_smag_next;
        post_sneg_reg <= post_sneg_next;
        post_hp_reg   <= cd_side[CORDIC_STEPS][QUAL_W];
        post_q_reg    <= cd_side[CORDIC_STEPS][QUAL_W-1:0];
    end

    // ------------------------------------------------------------------
    // alpha magnitude: |sin| * 2048 / q, truncated
    // ------------------------------------------------------------------
    logic                     al_valid [0:AL_N];
    logic [QUAL_W-1:0]        al_den   [0:AL_N];
    logic [0:0][AL_ACC_W-1:0] al_acc   [0:AL_N];
    logic [AL_SIDE_W-1:0]     al_side  [0:AL_N];

    assign al_valid[0]  = post_valid_reg;
    assign al_den[0]    = post_q_reg;
    assign al_acc[0][0] = {{QUAL_W{1'b0}}, post_smag_reg, {QSCALE{1'b0}}};
    assign al_side[0]   = {post_sneg_reg, post_hp_reg, post_c_reg};

    for (genvar k = 0; k < AL_N; k++)
    begin : g_alpha
        bqcd_div_cell #(
            .REM_W  (QUAL_W),
            .N_W    (AL_N),
            .LANES  (1),
            .SIDE_W (AL_SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (al_valid[k]),
            .in_den    (al_den[k]),
            .in_acc    (al_acc[k]),
            .in_side   (al_side[k]),
            .out_valid (al_valid[k+1]),
            .out_den   (al_den[k+1]),
            .out_acc   (al_acc[k+1]),
            .out_side  (al_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // n1: signed alpha
    // ------------------------------------------------------------------
    logic                    n1_valid_reg;
    logic signed [NUM_W-1:0] n1_alpha_reg, n1_alpha_next;
    logic signed [NUM_W-1:0] n1_c_reg;
    logic                    n1_hp_reg;
    logic signed [NUM_W-1:0] al_q;
    logic signed [CORDIC_W-1:0] al_c;

    assign al_q = $signed(al_acc[AL_N][0][NUM_W-1:0]);
    assign al_c = $signed(al_side[AL_N][CORDIC_W-1:0]);
    assign n1_alpha_next = al_side[AL_N][AL_SIDE_W-1] ? -al_q : al_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_valid_reg <= 1'b0;
        end
        else
        begin
            n1_valid_reg <= al_valid[AL_N];
        end
    end

    always_ff @(posedge clk)
    begin
        n1_alpha_reg <= n1_alpha_next;
        n1_c_reg     <= NUM_W'(al_c);
        n1_hp_reg    <= al_side[AL_N][CORDIC_W];
    end

    // ------------------------------------------------------------------
    // n2: cookbook numerators and a0
    // ------------------------------------------------------------------
    logic                    n2_valid_reg;
    logic signed [NUM_W-1:0] n2_num_reg  [CF_LANES];
    logic signed [NUM_W-1:0] n2_num_next [CF_LANES];
    logic signed [NUM_W-1:0] n2_den_reg, n2_den_next;
    logic signed [NUM_W-1:0] one_plus_c, one_minus_c;

    always_comb
    begin
        one_plus_c  = ONE_Q30 + n1_c_reg;
        one_minus_c = ONE_Q30 - n1_c_reg;
        if (n1_hp_reg)
        begin
            n2_num_next[LANE_B0] = one_plus_c >>> 1;
            n2_num_next[LANE_B1] = -one_plus_c;
        end
        else
        begin
            n2_num_next[LANE_B0] = one_minus_c >>> 1;
            n2_num_next[LANE_B1] = one_minus_c;
        end
        n2_num_next[LANE_A1] = -(n1_c_reg <<< 1);
        n2_num_next[LANE_A2] = ONE_Q30 - n1_alpha_reg;
        n2_den_next          = ONE_Q30 + n1_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n2_valid_reg <= 1'b0;
        end
        else
        begin
            n2_valid_reg <= n1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n2_num_reg <= n2_num_next;
        n2_den_reg <= n2_den_next;
    end

    // ------------------------------------------------------------------
    // n3: sign and magnitude
    // ------------------------------------------------------------------
    logic                n3_valid_reg;
    logic [MAG_W-1:0]    n3_mag_reg  [CF_LANES];
    logic [MAG_W-1:0]    n3_mag_next [CF_LANES];
    logic [CF_LANES-1:0] n3_neg_reg, n3_neg_next;
    logic [MAG_W-1:0]    n3_dmag_reg, n3_dmag_next;
    logic                n3_dneg_reg;

    always_comb
    begin
        logic signed [NUM_W-1:0] a;
        for (int l = 0; l < CF_LANES; l++)
        begin
            n3_neg_next[l] = n2_num_reg[l][NUM_W-1];
            a              = n3_neg_next[l] ? -n2_num_reg[l] : n2_num_reg[l];
            n3_mag_next[l] = a[MAG_W-1:0];
        end
        a            = n2_den_reg[NUM_W-1] ? -n2_den_reg : n2_den_reg;
        n3_dmag_next = a[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n3_valid_reg <= 1'b0;
        end
        else
        begin
            n3_valid_reg <= n2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n3_mag_reg  <= n3_mag_next;
        n3_neg_reg  <= n3_neg_next;
        n3_dmag_reg <= n3_dmag_next;
        n3_dneg_reg <= n2_den_reg[NUM_W-1];
    end

    // ------------------------------------------------------------------
    // n4: overflow pre-test and divider load
    // a quotient of 2^32 or more saturates; else the high part of the
    // scaled numerator is already below the divisor
    // ------------------------------------------------------------------
    logic                               n4_valid_reg;
    logic [CF_LANES-1:0][CF_ACC_W-1:0]  n4_acc_reg, n4_acc_next;
    logic [MAG_W-1:0]                   n4_den_reg;
    logic [CF_SIDE_W-1:0]               n4_side_reg, n4_side_next;

    always_comb
    begin
        logic [SH_W-1:0] sh;
        logic            ovf;
        for (int l = 0; l < CF_LANES; l++)
        begin
            sh  = {n3_mag_reg[l], {COEF_FRAC_BITS{1'b0}}};
            ovf = {{SHIFT_W{1'b0}}, n3_mag_reg[l]} >= {n3_dmag_reg, {SHIFT_W{1'b0}}};
            n4_acc_next[l] = {{SHIFT_W{1'b0}}, sh};
            n4_side_next[3*l+2] = ovf;
            n4_side_next[3*l+1] = n3_neg_reg[l] ^ n3_dneg_reg;
            n4_side_next[3*l]   = (n3_mag_reg[l] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n4_valid_reg <= 1'b0;
        end
        else
        begin
            n4_valid_reg <= n3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n4_acc_reg  <= n4_acc_next;
        n4_den_reg  <= n3_dmag_reg;
        n4_side_reg <= n4_side_next;
    end

    // ------------------------------------------------------------------
    // coefficient division, four lanes sharing |a0|
    // ------------------------------------------------------------------
    logic                              cf_valid [0:CF_N];
    logic [MAG_W-1:0]                  cf_den   [0:CF_N];
    logic [CF_LANES-1:0][CF_ACC_W-1:0] cf_acc   [0:CF_N];
    logic [CF_SIDE_W-1:0]              cf_side  [0:CF_N];

    assign cf_valid[0] = n4_valid_reg;
    assign cf_den[0]   = n4_den_reg;
    assign cf_acc[0]   = n4_acc_reg;
    assign cf_side[0]  = n4_side_reg;

    for (genvar k = 0; k < CF_N; k++)
    begin : g_coef
        bqcd_div_cell #(
            .REM_W  (MAG_W),
            .N_W    (CF_N),
            .LANES  (CF_LANES),
            .SIDE_W (CF_SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cf_valid[k]),
            .in_den    (cf_den[k]),
            .in_acc    (cf_acc[k]),
            .in_side   (cf_side[k]),
            .out_valid (cf_valid[k+1]),
            .out_den   (cf_den[k+1]),
            .out_acc   (cf_acc[k+1]),
            .out_side  (cf_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // sign, saturation and result register
    // ------------------------------------------------------------------
    logic                     done_reg;
    logic signed [COEF_W-1:0] res_reg  [CF_LANES];
    logic signed [COEF_W-1:0] res_next [CF_LANES];

    always_comb
    begin
        logic [COEF_W-1:0] q;
        logic              ovf, neg, zero;
        for (int l = 0; l < CF_LANES; l++)
        begin
            q    = cf_acc[CF_N][l][COEF_W-1:0];
            ovf  = cf_side[CF_N][3*l+2];
            neg  = cf_side[CF_N][3*l+1];
            zero = cf_side[CF_N][3*l];
            if (zero)
            begin
                res_next[l] = '0;
            end
            else if (ovf)
            begin
                // includes a zero a0: sign follows the numerator
                res_next[l] = neg ? COEF_MIN : COEF_MAX;
            end
            else if (neg)
            begin
                res_next[l] = (q > MIN_MAG) ? COEF_MIN : -$signed(q);
            end
            else
            begin
                res_next[l] = q[COEF_W-1] ? COEF_MAX : $signed(q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cf_valid[CF_N];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done         = done_reg;
    assign coef.coef_b0 = res_reg[LANE_B0];
    assign coef.coef_b1 = res_reg[LANE_B1];
    assign coef.coef_b2 = res_reg[LANE_B0];
    assign coef.coef_a1 = res_reg[LANE_A1];
    assign coef.coef_a2 = res_reg[LANE_A2];

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // every command transfer comes out after the fixed latency
    `BQCD_ASSERT_DLY(a_latency, clk, rst_n, start && !busy, LATENCY, done)
    // without overflow, lane 0 of the divider starts with a remainder below |a0|
    `BQCD_ASSERT_IMP(a_div_load, clk, rst_n, n4_valid_reg && !n4_side_reg[2], n4_acc_reg[0][CF_ACC_W-1:CF_N] < n4_den_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/bqcd_div_cell.sv =====
// ----------------------------------------------------------------------------
// bqcd_div_cell
// one restoring division step per cell, lanes share divisor and sideband
// ----------------------------------------------------------------------------
`default_nettype none

module bqcd_div_cell #(
    parameter int REM_W  = 16,
    parameter int N_W    = 32,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [REM_W-1:0]                   in_den,
    input  logic [LANES-1:0][REM_W+N_W-1:0]    in_acc,
    input  logic [SIDE_W-1:0]                  in_side,
    output logic                               out_valid,
    output logic [REM_W-1:0]                   out_den,
    output logic [LANES-1:0][REM_W+N_W-1:0]    out_acc,
    output logic [SIDE_W-1:0]                  out_side
);

    localparam int ACC_W = REM_W + N_W;

    logic                        valid_reg;
    logic [REM_W-1:0]            den_reg;
    logic [LANES-1:0][ACC_W-1:0] acc_reg;
    logic [LANES-1:0][ACC_W-1:0] acc_next;
    logic [SIDE_W-1:0]           side_reg;

    always_comb
    begin
        logic [REM_W+1:0] trial;
        for (int l = 0; l < LANES; l++)
        begin
            // shift in next dividend bit, subtract divisor if it fits
            trial = {1'b0, in_acc[l][ACC_W-1:N_W-1]} - {2'b00, in_den};
            if (!trial[REM_W+1])
            begin
                acc_next[l] = {trial[REM_W-1:0], in_acc[l][N_W-2:0], 1'b1};
            end
            else
            begin
                acc_next[l] = {in_acc[l][ACC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= in_den;
        acc_reg  <= acc_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_acc   = acc_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bqcd_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// bqcd_cordic_cell
// one rotation-mode cordic micro-rotation, fixed step index
// ----------------------------------------------------------------------------
`default_nettype none

module bqcd_cordic_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic signed [bqcd_pkg::CORDIC_W-1:0]  in_x,
    input  logic signed [bqcd_pkg::CORDIC_W-1:0]  in_y,
    input  logic signed [bqcd_pkg::CORDIC_W-1:0]  in_z,
    input  logic [SIDE_W-1:0]                     in_side,
    output logic                                  out_valid,
    output logic signed [bqcd_pkg::CORDIC_W-1:0]  out_x,
    output logic signed [bqcd_pkg::CORDIC_W-1:0]  out_y,
    output logic signed [bqcd_pkg::CORDIC_W-1:0]  out_z,
    output logic [SIDE_W-1:0]                     out_side
);

    import bqcd_pkg::*;

    localparam logic signed [CORDIC_W-1:0] ANGLE =
        $signed({{(CORDIC_W-PHASE_W){1'b0}}, atan_turn(STEP)});

    logic                       valid_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
    logic [SIDE_W-1:0]          side_reg;
    logic signed [CORDIC_W-1:0] dx, dy;

    assign dx = in_x >>> STEP;
    assign dy = in_y >>> STEP;

    always_comb
    begin
        if (!in_z[CORDIC_W-1])
        begin
            x_next = in_x - dy;
            y_next = in_y + dx;
            z_next = in_z - ANGLE;
        end
        else
        begin
            x_next = in_x + dy;
            y_next = in_y - dx;
            z_next = in_z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// biquad coefficient designer testbench
// random and directed lp/hp commands over several sample rates; an in-bench
// fixed-point model predicts each coefficient set and a scoreboard checks it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

    import bqcd_pkg::*;

    localparam int FRAC     = 29;
    localparam int STEPS    = 24;
    localparam int LATENCY  = 129 + STEPS;
    localparam int N_RANDOM = 700;

    // expected coefficient sets, oldest first
    class coef_scoreboard;
        coef_t pending_sets[$];
        int    mismatches;

        function void note_command(coef_t expected);
            pending_sets.push_back(expected);
        endfunction

        function void check_result(coef_t actual);
            coef_t expected;
            if (pending_sets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected coefficient set %h", actual);
                return;
            end
            expected = pending_sets.pop_front();
            if (actual !== expected)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("coef mismatch: exp b0 %h b1 %h b2 %h a1 %h a2 %h",
                             expected.coef_b0, expected.coef_b1, expected.coef_b2,
                             expected.coef_a1, expected.coef_a2,
                             " got b0 %h b1 %h b2 %h a1 %h a2 %h",
                             actual.coef_b0, actual.coef_b1, actual.coef_b2,
                             actual.coef_a1, actual.coef_a2);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    cmd_t               cmd;
    logic               done;
    coef_t              coef;
    logic               cfg_we;
    logic [SR_W-1:0]    cfg_wdata;

    coef_scoreboard     coef_sb;
    logic [SR_W-1:0]    model_rate;   // predictor copy of the sample rate register

    biquad_coefficient_designer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .coef      (coef),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // arithmetic shift right that rounds toward minus infinity
    function automatic longint asr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // atan(2^-i) in turns, q0.32, written out independently of the rtl
    function automatic int unsigned atan_table(int i);
        int unsigned t [0:31] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
            326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
        return t[i];
    endfunction

    // one coefficient: trunc(num * 2^frac / den), saturated, zero den to sign
    function automatic logic [31:0] scale_coef(longint num, longint den);
        longint q;
        if (den == 0)
            q = (num > 0) ? 64'sd2147483647 : ((num < 0) ? -64'sd2147483648 : 0);
        else
        begin
            q = (num * (longint'(1) << FRAC)) / den;
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            else if (q < -64'sd2147483648)
                q = -64'sd2147483648;
        end
        return q[31:0];
    endfunction

    // full cookbook computation for one command
    function automatic coef_t design_biquad(cmd_t c, logic [SR_W-1:0] rate);
        longint unsigned fs;
        longint unsigned phase;
        logic [1:0]      quad;
        logic            flip;
        longint          x, y, z, dx, dy, cosv, sinv, alpha, a0, bnum, b1num, qv;
        coef_t           r;
        fs = (rate == 0) ? 1 : rate;
        phase = ((longint'(c.cutoff_hz) << 32) / fs) & 64'hFFFF_FFFF;
        quad = phase[31:30];
        flip = (quad == 2'd1) || (quad == 2'd2);
        if (flip)
            z = longint'(phase) - (longint'(1) << 31);
        else
            z = (phase >= 64'h8000_0000) ? longint'(phase) - (longint'(1) << 32)
                                        : longint'(phase);
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = asr_floor(x, i);
            dy = asr_floor(y, i);
            if (z >= 0)
            begin
                x = x - dy;
                y = y + dx;
                z = z - longint'(atan_table(i));
            end
            else
            begin
                x = x + dy;
                y = y - dx;
                z = z + longint'(atan_table(i));
            end
        end
        cosv = flip ? -x : x;
        sinv = flip ? -y : y;
        qv = (c.quality < 410) ? 410 : c.quality;
        alpha = (sinv * 2048) / qv;
        a0 = (longint'(1) << 30) + alpha;
        if (c.command == CMD_HIGHPASS)
        begin
            bnum  = asr_floor((longint'(1) << 30) + cosv, 1);
            b1num = -((longint'(1) << 30) + cosv);
        end
        else
        begin
            bnum  = asr_floor((longint'(1) << 30) - cosv, 1);
            b1num = (longint'(1) << 30) - cosv;
        end
        r.coef_b0 = scale_coef(bnum, a0);
        r.coef_b1 = scale_coef(b1num, a0);
        r.coef_b2 = r.coef_b0;
        r.coef_a1 = scale_coef(-2 * cosv, a0);
        r.coef_a2 = scale_coef((longint'(1) << 30) - alpha, a0);
        return r;
    endfunction

    // idle stretch: mostly short, now and then long; start drops only for a real gap
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if (n > 0)
            start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // issue one command transfer and record its expected result
    // start stays high afterwards so transfers can follow back to back
    task automatic send_command(logic op, logic [FC_W-1:0] fc, logic [QUAL_W-1:0] q);
        cmd_t c;
        c.command   = op;
        c.cutoff_hz = fc;
        c.quality   = q;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        coef_sb.note_command(design_biquad(c, model_rate));
    endtask

    // wait for all sets to drain, then update the sample rate
    task automatic write_rate(logic [SR_W-1:0] rate);
        start <= 1'b0;
        while (coef_sb.pending_sets.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= rate;
        @(posedge clk);
        cfg_we     <= 1'b0;
        model_rate  = rate;
    endtask

    // random command, biased toward audio-band cutoffs and normal q
    task automatic random_command(logic [SR_W-1:0] rate);
        logic [FC_W-1:0]   fc;
        logic [QUAL_W-1:0] q;
        case ($urandom_range(0, 9))
            0:       fc = FC_W'($urandom);                             // any 17-bit value
            1:       fc = FC_W'(rate / 2 + $urandom_range(0, 20) - 10); // near nyquist
            default: fc = FC_W'($urandom_range(1, (rate > 4) ? rate / 2 : 1));
        endcase
        case ($urandom_range(0, 7))
            0:       q = QUAL_W'($urandom);
            1:       q = QUAL_W'($urandom_range(0, 420));               // around the q floor
            default: q = QUAL_W'($urandom_range(1500, 20000));
        endcase
        send_command(1'($urandom_range(0, 1)), fc, q);
    endtask

    // compare every done strobe against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
            coef_sb.check_result(coef);
    end

    initial
    begin
        logic [SR_W-1:0] rates [0:5] = '{18'd48000, 18'd8000, 18'd192000,
                                         18'd44100, 18'd0, 18'h3FFFF};
        coef_sb    = new();
        model_rate = SR_RESET;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, both modes, q floor, nyquist and wrap
        send_command(CMD_LOWPASS,  17'd1,      16'd0);
        send_command(CMD_HIGHPASS, 17'd1,      16'hFFFF);
        send_command(CMD_LOWPASS,  17'd1000,   16'd409);
        send_command(CMD_HIGHPASS, 17'd1000,   16'd410);
        send_command(CMD_LOWPASS,  17'd24000,  16'd2896);
        send_command(CMD_HIGHPASS, 17'd24000,  16'd2896);
        send_command(CMD_LOWPASS,  17'd12000,  16'd410);
        send_command(CMD_HIGHPASS, 17'd36000,  16'd410);
        send_command(CMD_LOWPASS,  17'd48000,  16'd4096);
        send_command(CMD_HIGHPASS, 17'h1FFFF,  16'd4096);
        send_command(CMD_LOWPASS,  17'd0,      16'd4096);
        send_command(CMD_HIGHPASS, 17'h15555,  16'hAAAA);
        send_command(CMD_LOWPASS,  17'h0AAAA,  16'h5555);
        send_command(CMD_HIGHPASS, 17'd96000,  16'd1);
        // zero sample rate and full-scale register value
        write_rate(18'd0);
        send_command(CMD_LOWPASS,  17'd0,      16'd4096);
        send_command(CMD_HIGHPASS, 17'd1,      16'd4096);
        write_rate(18'h3FFFF);
        send_command(CMD_LOWPASS,  17'h1FFFF,  16'd410);
        send_command(CMD_HIGHPASS, 17'd100,    16'hFFFF);

        // random phases over several sample rates, back-to-back stretches included
        for (int ph = 0; ph < 6; ph++)
        begin
            write_rate(rates[ph]);
            for (int k = 0; k < N_RANDOM / 6; k++)
            begin
                if (ph != 2 || k > 40)
                    idle_gap();
                random_command(rates[ph]);
            end
        end
        start <= 1'b0;

        while (coef_sb.pending_sets.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (coef_sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // generous limit: ~720 items with long gaps plus drains
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== biquad_coefficient_designer.f =====
+incdir+hw/rtl
hw/rtl/bqcd_pkg.sv
hw/rtl/bqcd_div_cell.sv
hw/rtl/bqcd_cordic_cell.sv
hw/rtl/biquad_coefficient_designer.sv
verif/tb.sv
